@@ rtl/core/pbu_pkg.sv @@
// ----------------------------------------------------------------------------
// pbu_pkg
// Shared widths, types and codes of the pixel blend unit.
// ----------------------------------------------------------------------------
package pbu_pkg;

	// channel width and derived widths
	localparam int CHANNEL_BITS  = 8;
	localparam int CW            = CHANNEL_BITS;
	localparam int PW            = 2 * CW;        // channel product
	localparam int MW            = 3 * CW;        // colour times weight
	localparam int NW            = 3 * CW + 1;    // dividend
	localparam int DW            = 2 * CW + 1;    // divisor
	localparam int LANES         = 4;
	localparam int COLOURS       = 3;
	localparam int LANE_A        = 3;             // alpha lane
	localparam logic [CW-1:0] CH_FULL = {CW{1'b1}};
	// half an LSB of the result, added before a divide by full scale
	localparam logic [PW-1:0] ROUND_HALF = PW'(1) << (CW - 1);

	// configuration port
	localparam int MIN_ALPHA_BITS = 8;
	localparam int CFG_DATA_BITS  = 8;
	localparam int REG_IDX_BITS   = 1;
	localparam logic [REG_IDX_BITS-1:0] REG_BLEND_MODE = 1'b0;
	localparam logic [REG_IDX_BITS-1:0] REG_MIN_ALPHA  = 1'b1;
	localparam logic [MIN_ALPHA_BITS-1:0] MIN_ALPHA_RST = 8'd1;
	localparam int TW = (CW > MIN_ALPHA_BITS) ? CW : MIN_ALPHA_BITS;

	// pipeline depth
	localparam int FRONT_STAGES = 3;
	localparam int DIV_STAGES   = CW;             // one quotient bit per stage
	localparam int NSTG         = FRONT_STAGES + DIV_STAGES + 1;

	typedef enum logic [1:0] {
		MODE_OVER = 2'd0,
		MODE_MUL  = 2'd1,
		MODE_ADD  = 2'd2,
		MODE_AVG  = 2'd3
	} blend_mode_t;

	typedef logic [LANES-1:0][CW-1:0]   pix_t;
	typedef logic [COLOURS-1:0][CW-1:0] col_t;
	typedef logic [LANES-1:0][PW-1:0]   prod_vec_t;
	typedef logic [COLOURS-1:0][MW-1:0] wprod_vec_t;
	typedef logic [COLOURS-1:0][NW-1:0] dvd_vec_t;
	typedef logic [COLOURS-1:0][DW-1:0] dvs_vec_t;

	// sideband that rides along the divider
	typedef struct packed {
		blend_mode_t mode;
		logic        den_zero;
		pix_t        simple;
	} pbu_tag_t;

endpackage

@@ rtl/core/pbu_front.sv @@
// ----------------------------------------------------------------------------
// pbu_front
// Weights, products and divider operands: three pipeline stages.
// ----------------------------------------------------------------------------
module pbu_front (
	input  logic                              clk,
	input  logic [pbu_pkg::FRONT_STAGES-1:0]  en,
	input  pbu_pkg::blend_mode_t              mode,
	input  pbu_pkg::pix_t                     bg,
	input  pbu_pkg::pix_t                     fg,
	output pbu_pkg::dvd_vec_t                 dvd,
	output pbu_pkg::dvs_vec_t                 dvs,
	output pbu_pkg::pbu_tag_t                 tag
);
	import pbu_pkg::*;

	logic [CW:0]   sum_c [COLOURS];
	pix_t          simple_c;

	logic [PW-1:0] fw_s1;
	logic [PW-1:0] bw_s1;
	prod_vec_t     prod_s1;
	col_t          bg_s1;
	col_t          fg_s1;
	pix_t          simple_s1;
	blend_mode_t   mode_s1;

	wprod_vec_t    pf_s2;
	wprod_vec_t    pb_s2;
	logic [PW-1:0] den_s2;
	prod_vec_t     prod_s2;
	pix_t          simple_s2;
	blend_mode_t   mode_s2;

	logic [MW-1:0] num_c [COLOURS];
	dvd_vec_t      dvd_c;
	dvs_vec_t      dvs_c;
	logic [PW-1:0] rnd_c [LANES];
	pix_t          scaled_c;
	pix_t          simple_nx_c;

	dvd_vec_t      dvd_s3;
	dvs_vec_t      dvs_s3;
	pbu_tag_t      tag_s3;

	// saturated sum for add, truncated mean for average, larger alpha
	always_comb begin
		for (int l = 0; l < COLOURS; l++) begin
			sum_c[l] = {1'b0, bg[l]} + {1'b0, fg[l]};
			if (mode == MODE_ADD) begin
				simple_c[l] = sum_c[l][CW] ? CH_FULL : sum_c[l][CW-1:0];
			end else begin
				simple_c[l] = sum_c[l][CW:1];
			end
		end
		simple_c[LANE_A] = (bg[LANE_A] > fg[LANE_A]) ? bg[LANE_A] : fg[LANE_A];
	end

	// stage 1: alpha weights and channel products
	always_ff @(posedge clk) begin
		if (en[0]) begin
			fw_s1 <= (PW'(fg[LANE_A]) << CW) - PW'(fg[LANE_A]);
			bw_s1 <= PW'(bg[LANE_A]) * PW'(CH_FULL - fg[LANE_A]);
			for (int l = 0; l < LANES; l++) begin
				prod_s1[l] <= PW'(bg[l]) * PW'(fg[l]);
			end
			for (int l = 0; l < COLOURS; l++) begin
				bg_s1[l] <= bg[l];
				fg_s1[l] <= fg[l];
			end
			simple_s1 <= simple_c;
			mode_s1   <= mode;
		end
	end

	// stage 2: weighted colours and new alpha numerator
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int l = 0; l < COLOURS; l++) begin
				pf_s2[l] <= MW'(fg_s1[l]) * MW'(fw_s1);
				pb_s2[l] <= MW'(bg_s1[l]) * MW'(bw_s1);
			end
			den_s2    <= fw_s1 + bw_s1;
			prod_s2   <= prod_s1;
			simple_s2 <= simple_s1;
			mode_s2   <= mode_s1;
		end
	end

	// build rounded dividend and doubled divisor per colour lane
	always_comb begin
		for (int l = 0; l < COLOURS; l++) begin
			num_c[l] = pf_s2[l] + pb_s2[l];
			dvd_c[l] = (NW'(num_c[l]) << 1) + NW'(den_s2);
			dvs_c[l] = DW'(den_s2) << 1;
		end
	end

	// rounded divide by full scale with shift and add: products, new alpha
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (mode_s2 == MODE_OVER && l == LANE_A) begin
				rnd_c[l] = den_s2 + ROUND_HALF;
			end else begin
				rnd_c[l] = prod_s2[l] + ROUND_HALF;
			end
			scaled_c[l] = CW'((rnd_c[l] + (rnd_c[l] >> CW)) >> CW);
		end
		simple_nx_c = simple_s2;
		unique case (mode_s2)
			MODE_OVER:          simple_nx_c[LANE_A] = scaled_c[LANE_A];
			MODE_MUL:           simple_nx_c = scaled_c;
			MODE_ADD, MODE_AVG: ;
		endcase
	end

	// stage 3: divider operands
	always_ff @(posedge clk) begin
		if (en[2]) begin
			dvd_s3          <= dvd_c;
			dvs_s3          <= dvs_c;
			tag_s3.mode     <= mode_s2;
			tag_s3.den_zero <= (den_s2 == '0);
			tag_s3.simple   <= simple_nx_c;
		end
	end

	assign dvd = dvd_s3;
	assign dvs = dvs_s3;
	assign tag = tag_s3;

endmodule

@@ rtl/core/pbu_divider.sv @@
// ----------------------------------------------------------------------------
// pbu_divider
// Pipelined restoring divider, three colour lanes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pbu_divider (
	input  logic                            clk,
	input  logic [pbu_pkg::DIV_STAGES-1:0]  en,
	input  pbu_pkg::dvd_vec_t               dvd,
	input  pbu_pkg::dvs_vec_t               dvs,
	input  pbu_pkg::pbu_tag_t               tag_in,
	output pbu_pkg::col_t                   quo,
	output pbu_pkg::pbu_tag_t               tag_out
);
	import pbu_pkg::*;

	dvd_vec_t rem_sn [DIV_STAGES];
	dvs_vec_t dvs_sn [DIV_STAGES];
	col_t     quo_sn [DIV_STAGES];
	pbu_tag_t tag_sn [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		localparam int K = DIV_STAGES - 1 - j;

		dvd_vec_t      rem_in;
		dvd_vec_t      rem_nx;
		dvs_vec_t      dvs_in;
		col_t          quo_in;
		col_t          quo_nx;
		pbu_tag_t      tag_w;
		logic [NW-1:0] trial [COLOURS];

		if (j == 0) begin : g_first
			assign rem_in = dvd;
			assign dvs_in = dvs;
			assign quo_in = '0;
			assign tag_w  = tag_in;
		end else begin : g_next
			assign rem_in = rem_sn[j-1];
			assign dvs_in = dvs_sn[j-1];
			assign quo_in = quo_sn[j-1];
			assign tag_w  = tag_sn[j-1];
		end

		// trial subtract of the shifted divisor
		always_comb begin
			rem_nx = rem_in;
			quo_nx = quo_in;
			for (int l = 0; l < COLOURS; l++) begin
				trial[l] = NW'(dvs_in[l]) << K;
				if (rem_in[l] >= trial[l]) begin
					rem_nx[l]    = rem_in[l] - trial[l];
					quo_nx[l][K] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_sn[j] <= rem_nx;
				dvs_sn[j] <= dvs_in;
				quo_sn[j] <= quo_nx;
				tag_sn[j] <= tag_w;
			end
		end
	end

	assign quo     = quo_sn[DIV_STAGES-1];
	assign tag_out = tag_sn[DIV_STAGES-1];

endmodule

@@ rtl/core/pixel_blend_unit_core.sv @@
// ----------------------------------------------------------------------------
// pixel_blend_unit_core
// RGBA blender: alpha over, multiply, add and average of two pixels.
// ----------------------------------------------------------------------------
// Takes one background/foreground pixel pair per clock and returns one
// blended pixel per clock once the pipeline is full, while blend_ready is
// high. Three stages form the weights, the products and the rounded
// divides by full scale (shift and add), a restoring divider resolves one
// quotient bit per stage for the rounded colour divide by the new alpha,
// and one output register selects the result. Each stage holds on its own
// when the next one is full and cannot move, so bubbles close up and a
// request can still be taken while a finished pixel waits on blend_ready,
// as long as a stage is empty. Write blend_mode and min_alpha only while
// no pixel is in flight.
module pixel_blend_unit_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pbu_pkg::REG_IDX_BITS-1:0]      cfg_idx,
	input  logic [pbu_pkg::CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                                  pair_valid,
	output logic                                  pair_ready,
	input  logic [pbu_pkg::CW-1:0]                bg_red,
	input  logic [pbu_pkg::CW-1:0]                bg_green,
	input  logic [pbu_pkg::CW-1:0]                bg_blue,
	input  logic [pbu_pkg::CW-1:0]                bg_alpha,
	input  logic [pbu_pkg::CW-1:0]                fg_red,
	input  logic [pbu_pkg::CW-1:0]                fg_green,
	input  logic [pbu_pkg::CW-1:0]                fg_blue,
	input  logic [pbu_pkg::CW-1:0]                fg_alpha,
	output logic                                  blend_valid,
	input  logic                                  blend_ready,
	output logic [pbu_pkg::CW-1:0]                out_red,
	output logic [pbu_pkg::CW-1:0]                out_green,
	output logic [pbu_pkg::CW-1:0]                out_blue,
	output logic [pbu_pkg::CW-1:0]                out_alpha
);
	import pbu_pkg::*;

	blend_mode_t               blend_mode_q;
	logic [MIN_ALPHA_BITS-1:0] min_alpha_q;
	logic [NSTG-1:0]           stg_valid_q;
	logic [NSTG:0]             en;

	pix_t     bg;
	pix_t     fg;
	dvd_vec_t dvd;
	dvs_vec_t dvs;
	pbu_tag_t tag_front;
	col_t     quo;
	pbu_tag_t tag_div;

	logic     low_alpha;
	pix_t     res_c;
	pix_t     res_sout;
	blend_mode_t mode_sout;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q <= MODE_OVER;
			min_alpha_q  <= MIN_ALPHA_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_BLEND_MODE: blend_mode_q <= blend_mode_t'(cfg_data[1:0]);
				REG_MIN_ALPHA:  min_alpha_q  <= cfg_data[MIN_ALPHA_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage advances when empty or when the next one moves
	always_comb begin
		en[NSTG] = blend_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			en[k] = !stg_valid_q[k] || en[k+1];
		end
	end

	assign pair_ready  = en[0];
	assign blend_valid = stg_valid_q[NSTG-1];

	// advance valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= '0;
		end else begin
			if (en[0]) begin
				stg_valid_q[0] <= pair_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) begin
					stg_valid_q[k] <= stg_valid_q[k-1];
				end
			end
		end
	end

	assign bg = {bg_alpha, bg_blue, bg_green, bg_red};
	assign fg = {fg_alpha, fg_blue, fg_green, fg_red};

	pbu_front u_front (
		.clk  (clk),
		.en   (en[FRONT_STAGES-1:0]),
		.mode (blend_mode_q),
		.bg   (bg),
		.fg   (fg),
		.dvd  (dvd),
		.dvs  (dvs),
		.tag  (tag_front)
	);

	pbu_divider u_divider (
		.clk     (clk),
		.en      (en[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
		.dvd     (dvd),
		.dvs     (dvs),
		.tag_in  (tag_front),
		.quo     (quo),
		.tag_out (tag_div)
	);

	// select result; alpha over drops to transparent black below the alpha threshold
	always_comb begin
		low_alpha = TW'(tag_div.simple[LANE_A]) < TW'(min_alpha_q);
		unique case (tag_div.mode)
			MODE_OVER: begin
				res_c = (low_alpha || tag_div.den_zero) ? '0 :
					{tag_div.simple[LANE_A], quo};
			end
			MODE_MUL, MODE_ADD, MODE_AVG: res_c = tag_div.simple;
		endcase
	end

	// output register
	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			res_sout  <= res_c;
			mode_sout <= tag_div.mode;
		end
	end

	assign out_red   = res_sout[0];
	assign out_green = res_sout[1];
	assign out_blue  = res_sout[2];
	assign out_alpha = res_sout[LANE_A];

	// an empty output stage never blocks a request
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!blend_valid |-> pair_ready)
		else $error("request blocked with empty output stage");

	// a full, stalled pipeline takes no request
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(&stg_valid_q) && !blend_ready |-> !pair_ready)
		else $error("request taken while pipeline full and stalled");

	// alpha over never gives a visible alpha below the threshold
	a_over_threshold: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && mode_sout == MODE_OVER && out_alpha != '0
		|-> TW'(out_alpha) >= TW'(min_alpha_q))
		else $error("alpha over result below threshold");

	// alpha over with zero alpha is transparent black
	a_over_black: assert property (@(posedge clk) disable iff (!arst_n)
		blend_valid && mode_sout == MODE_OVER && out_alpha == '0
		|-> out_red == '0 && out_green == '0 && out_blue == '0)
		else $error("transparent alpha over result carries colour");

endmodule
